// ----- design/acdc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acdc_pkg: shared types and constants for the amount compression core
// Request and result structs, microcode word layout, datapath operations,
// branch conditions and the control program itself.
// ----------------------------------------------------------------------------
package acdc_pkg;

    localparam int unsigned VAL_W = 64;
    localparam int unsigned PC_W  = 5;

    typedef struct packed {
        logic             command;
        logic [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0] result;
        logic             overflow;
    } t_out;

    localparam logic CMD_COMPRESS   = 1'b0;
    localparam logic CMD_DECOMPRESS = 1'b1;

    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_DEC    = 4'd1;
    localparam logic [3:0] OP_INC    = 4'd2;
    localparam logic [3:0] OP_DIV10  = 4'd3;
    localparam logic [3:0] OP_DIV9   = 4'd4;
    localparam logic [3:0] OP_STRIP  = 4'd5;
    localparam logic [3:0] OP_SETE   = 4'd6;
    localparam logic [3:0] OP_CMUL9  = 4'd7;
    localparam logic [3:0] OP_CMUL10 = 4'd8;
    localparam logic [3:0] OP_DREB   = 4'd9;
    localparam logic [3:0] OP_MUL10  = 4'd10;
    localparam logic [3:0] OP_FIN    = 4'd11;

    localparam logic [2:0] C_NEXT     = 3'd0;
    localparam logic [2:0] C_ALWAYS   = 3'd1;
    localparam logic [2:0] C_N_ZERO   = 3'd2;
    localparam logic [2:0] C_CNT_MORE = 3'd3;
    localparam logic [2:0] C_E_NINE   = 3'd4;
    localparam logic [2:0] C_REM_NZ   = 3'd5;
    localparam logic [2:0] C_E_ZERO   = 3'd6;

    localparam logic [PC_W-1:0] ENTRY_CMP = 5'd0;
    localparam logic [PC_W-1:0] ENTRY_DEC = 5'd8;
    localparam logic [PC_W-1:0] PC_FIN    = 5'd19;

    localparam logic [3:0] E_MAX = 4'd9;

    // Reciprocals scaled by 2^23, exact for 20-bit dividends.
    localparam logic [19:0] RECIP10 = 20'd838861;
    localparam logic [19:0] RECIP9  = 20'd932068;

    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic n_zero;
        logic cnt_last;
        logic e_nine;
        logic e_zero;
        logic rem_nz;
    } t_status;

    function automatic t_ctrl ucode_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        case (pc)
            5'd0:    w = '{OP_NOP,    C_N_ZERO,   PC_FIN};
            5'd1:    w = '{OP_DIV10,  C_CNT_MORE, 5'd1};
            5'd2:    w = '{OP_NOP,    C_E_NINE,   5'd7};
            5'd3:    w = '{OP_NOP,    C_REM_NZ,   5'd5};
            5'd4:    w = '{OP_STRIP,  C_ALWAYS,   5'd1};
            5'd5:    w = '{OP_CMUL9,  C_NEXT,     5'd0};
            5'd6:    w = '{OP_CMUL10, C_ALWAYS,   PC_FIN};
            5'd7:    w = '{OP_MUL10,  C_ALWAYS,   PC_FIN};
            5'd8:    w = '{OP_NOP,    C_N_ZERO,   PC_FIN};
            5'd9:    w = '{OP_DEC,    C_NEXT,     5'd0};
            5'd10:   w = '{OP_DIV10,  C_CNT_MORE, 5'd10};
            5'd11:   w = '{OP_SETE,   C_NEXT,     5'd0};
            5'd12:   w = '{OP_NOP,    C_E_NINE,   5'd15};
            5'd13:   w = '{OP_DIV9,   C_CNT_MORE, 5'd13};
            5'd14:   w = '{OP_DREB,   C_ALWAYS,   5'd16};
            5'd15:   w = '{OP_INC,    C_NEXT,     5'd0};
            5'd16:   w = '{OP_NOP,    C_E_ZERO,   PC_FIN};
            5'd17:   w = '{OP_MUL10,  C_ALWAYS,   5'd16};
            5'd19:   w = '{OP_FIN,    C_ALWAYS,   PC_FIN};
            default: w = '{OP_NOP,    C_ALWAYS,   PC_FIN};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- design/acdc_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acdc_datapath: working registers and arithmetic units
// A 16-bit-per-step reciprocal divider by nine or ten, a shared
// shift-and-add multiply-accumulate by nine or ten with overflow detect,
// and the exponent and chunk counters.
// ----------------------------------------------------------------------------
module acdc_datapath (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_load,
    input  wire [acdc_pkg::VAL_W-1:0]   i_value,
    input  wire [3:0]                   i_op,
    output acdc_pkg::t_status           o_status,
    output logic [acdc_pkg::VAL_W-1:0]  o_result,
    output logic                        o_overflow
);
    import acdc_pkg::*;

    logic [VAL_W-1:0] r_n, n_n;
    logic [VAL_W-1:0] r_q, n_q;
    logic [3:0]       r_rem, n_rem;
    logic [3:0]       r_e, n_e;
    logic [1:0]       r_cnt, n_cnt;
    logic             r_ov, n_ov;

    logic [15:0]      div_chunk;
    logic [19:0]      div_t;
    logic [39:0]      div_p;
    logic [15:0]      div_q;
    logic [19:0]      div_qx;
    logic [19:0]      div_qd;
    logic [19:0]      div_r;
    logic             use_n;
    logic             times_ten;
    logic [3:0]       mac_add;
    logic [67:0]      mac_src;
    logic [67:0]      mac_w;
    logic             is_div;

    always_comb begin
        case (r_cnt)
            2'd0:    div_chunk = r_n[63:48];
            2'd1:    div_chunk = r_n[47:32];
            2'd2:    div_chunk = r_n[31:16];
            default: div_chunk = r_n[15:0];
        endcase
        div_t  = {((r_cnt == 2'd0) ? 4'd0 : r_rem), div_chunk};
        div_p  = 40'(div_t) * 40'((i_op == OP_DIV9) ? RECIP9 : RECIP10);
        div_q  = div_p[38:23];
        div_qx = {4'd0, div_q};
        div_qd = (i_op == OP_DIV9) ? ((div_qx << 3) + div_qx)
                                   : ((div_qx << 3) + (div_qx << 1));
        div_r  = div_t - div_qd;
    end

    always_comb begin
        use_n     = (i_op == OP_CMUL10) || (i_op == OP_MUL10);
        times_ten = (i_op != OP_CMUL9);
        case (i_op)
            OP_CMUL9:  mac_add = r_rem - 4'd1;
            OP_CMUL10: mac_add = r_e + 4'd1;
            OP_DREB:   mac_add = r_rem + 4'd1;
            default:   mac_add = 4'd0;
        endcase
        mac_src = {4'd0, (use_n ? r_n : r_q)};
        mac_w   = (mac_src << 3) + (times_ten ? (mac_src << 1) : mac_src)
                + {64'd0, mac_add};
    end

    always_comb begin
        n_n    = r_n;
        n_q    = r_q;
        n_rem  = r_rem;
        n_e    = r_e;
        n_ov   = r_ov;
        is_div = 1'b0;
        if (i_load) begin
            n_n  = i_value;
            n_e  = 4'd0;
            n_ov = 1'b0;
        end else begin
            case (i_op)
                OP_DEC:   n_n = r_n - 64'd1;
                OP_INC:   n_n = r_n + 64'd1;
                OP_DIV10, OP_DIV9: begin
                    is_div = 1'b1;
                    n_q    = {r_q[47:0], div_q};
                    n_rem  = div_r[3:0];
                end
                OP_STRIP: begin
                    n_n = r_q;
                    n_e = r_e + 4'd1;
                end
                OP_SETE: begin
                    n_n = r_q;
                    n_e = r_rem;
                end
                OP_CMUL9, OP_CMUL10, OP_DREB, OP_MUL10: begin
                    n_n  = mac_w[63:0];
                    n_ov = r_ov | (|mac_w[67:64]);
                    if (i_op == OP_MUL10) begin
                        n_e = r_e - 4'd1;
                    end
                end
                default: ;
            endcase
        end
        n_cnt = (i_load) ? 2'd0 : (is_div ? r_cnt + 2'd1 : r_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_e   <= n_e;
        r_ov  <= n_ov;
    end

    assign o_status.n_zero   = (r_n == 64'd0);
    assign o_status.cnt_last = (r_cnt == 2'd3);
    assign o_status.e_nine   = (r_e == E_MAX);
    assign o_status.e_zero   = (r_e == 4'd0);
    assign o_status.rem_nz   = (r_rem != 4'd0);
    assign o_result          = r_n;
    assign o_overflow        = r_ov;

endmodule
`default_nettype wire

// ----- design/acdc_useq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acdc_useq: microcode sequencer
// Step counter over the control program, conditional jumps on datapath
// status, and the finish step that hands the result to the output register.
// ----------------------------------------------------------------------------
module acdc_useq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_cmd,
    input  acdc_pkg::t_status   i_status,
    input  wire                 i_out_free,
    output logic                o_busy,
    output logic [3:0]          o_op,
    output logic                o_done
);
    import acdc_pkg::*;

    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_busy, n_busy;
    t_ctrl           word;
    logic            taken;
    logic            fin;

    always_comb begin
        word = ucode_word(r_pc);
        case (word.cond)
            C_NEXT:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_N_ZERO:   taken = i_status.n_zero;
            C_CNT_MORE: taken = !i_status.cnt_last;
            C_E_NINE:   taken = i_status.e_nine;
            C_REM_NZ:   taken = i_status.rem_nz;
            C_E_ZERO:   taken = i_status.e_zero;
            default:    taken = 1'b1;
        endcase
        fin    = r_busy && (word.op == OP_FIN);
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_start) begin
            n_pc   = (i_cmd == CMD_DECOMPRESS) ? ENTRY_DEC : ENTRY_CMP;
            n_busy = 1'b1;
        end else if (fin) begin
            if (i_out_free) begin
                n_busy = 1'b0;
            end
        end else if (r_busy) begin
            n_pc = taken ? word.target : r_pc + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= ENTRY_CMP;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_busy = r_busy;
    assign o_op   = r_busy ? word.op : OP_NOP;
    assign o_done = fin && i_out_free;

endmodule
`default_nettype wire

// ----- design/amount_compress_decompress_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amount_compress_decompress_core: amount compression and decompression
// The time from acceptance to registered result depends on the value: a zero
// value jumps straight to the finish step, others run through the chunked divides
// and the trailing zeros handled. One request is in work at a time; the next is taken
// the cycle after the result is registered.
// Synchronous active-low reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module amount_compress_decompress_core (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  acdc_pkg::t_in   i_in_data,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output acdc_pkg::t_out  o_out_data,
    input  wire             i_out_stall
);
    import acdc_pkg::*;

    logic             start;
    logic             busy;
    logic             done;
    logic             out_free;
    logic [3:0]       op;
    t_status          status;
    logic [VAL_W-1:0] dp_result;
    logic             dp_overflow;
    logic             r_out_vld;
    t_out             r_out;

    assign start    = i_in_valid && !busy;
    assign out_free = !r_out_vld || !i_out_stall;

    acdc_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_in_data.command),
        .i_status   (status),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_op       (op),
        .o_done     (done)
    );

    acdc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (start),
        .i_value    (i_in_data.value),
        .i_op       (op),
        .o_status   (status),
        .o_result   (dp_result),
        .o_overflow (dp_overflow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (done) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out.result   <= dp_result;
            r_out.overflow <= dp_overflow;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- design/acdc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acdc_checker: port-level checks for the amount compression core
// Watches the request and result channels and the reset behavior.
// ----------------------------------------------------------------------------
module acdc_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_in_valid,
    input wire             o_in_stall,
    input wire             o_out_valid,
    input acdc_pkg::t_out  o_out_data,
    input wire             i_out_stall
);
    import acdc_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but core did not go busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in work");

    a_finish_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_in_stall) && $past(i_rst_n)) |-> o_out_valid)
        else $error("core went idle without presenting a result");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset did not clear the channels");

endmodule

bind amount_compress_decompress_core acdc_checker u_acdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking testbench for amount_compress_decompress_core
// A directed table of amounts and codes runs first, then about 1700 random
// requests of both commands. Every result is checked against the table's typed
// values or an in-bench predictor, with random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import acdc_pkg::*;

    localparam int unsigned       CYCLE_LIMIT     = 1000000;
    localparam int unsigned       RANDOM_REQUESTS = 1700;
    localparam int unsigned       DRAIN_CYCLES    = 100;
    localparam int unsigned       DIRECTED_N      = 23;
    localparam logic [63:0]       DEC_RADIX       = 64'd10;
    localparam logic [63:0]       DIGIT_RADIX     = 64'd9;
    localparam logic [63:0]       ALL_ONES        = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic              TYPED           = 1'b1;
    localparam logic              PREDICTED       = 1'b0;

    typedef struct packed {
        logic        known;
        logic        command;
        logic [63:0] value;
        logic [63:0] result;
        logic        overflow;
    } t_vector;

    logic        i_clk       = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    t_in         in_data     = '0;
    logic        out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out_data;

    t_out        pending_amounts[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_request   = 0;
    logic        burst_mode     = 1'b0;

    t_vector directed_rows [DIRECTED_N] = '{
        '{TYPED,     CMD_COMPRESS,   64'd0,          64'd0,          1'b0},
        '{TYPED,     CMD_DECOMPRESS, 64'd0,          64'd0,          1'b0},
        '{TYPED,     CMD_COMPRESS,   64'd1,          64'd1,          1'b0},
        '{TYPED,     CMD_DECOMPRESS, 64'd1,          64'd1,          1'b0},
        '{TYPED,     CMD_COMPRESS,   64'd9,          64'd81,         1'b0},
        '{TYPED,     CMD_DECOMPRESS, 64'd9,          64'd100000000,  1'b0},
        '{TYPED,     CMD_COMPRESS,   64'd10,         64'd2,          1'b0},
        '{TYPED,     CMD_DECOMPRESS, 64'd2,          64'd10,         1'b0},
        '{TYPED,     CMD_COMPRESS,   64'd1000000000, 64'd10,         1'b0},
        '{TYPED,     CMD_DECOMPRESS, 64'd10,         64'd1000000000, 1'b0},
        '{TYPED,     CMD_COMPRESS,   ALL_ONES,       64'hFFFF_FFFF_FFFF_FFF3, 1'b1},
        '{PREDICTED, CMD_DECOMPRESS, ALL_ONES,       64'd0,          1'b0},
        '{PREDICTED, CMD_COMPRESS,   64'd10000000000000000000, 64'd0, 1'b0},
        '{PREDICTED, CMD_DECOMPRESS, 64'hFFFF_FFFF_FFFF_FFF9, 64'd0,  1'b0},
        '{PREDICTED, CMD_COMPRESS,   64'd1234000000000, 64'd0,       1'b0},
        '{PREDICTED, CMD_COMPRESS,   64'd12345678900, 64'd0,         1'b0},
        '{PREDICTED, CMD_COMPRESS,   64'h8000_0000_0000_0000, 64'd0, 1'b0},
        '{PREDICTED, CMD_DECOMPRESS, 64'h8000_0000_0000_0000, 64'd0, 1'b0},
        '{PREDICTED, CMD_DECOMPRESS, 64'hFFFF_FFFF_FFFF_FFF3, 64'd0, 1'b0},
        '{PREDICTED, CMD_DECOMPRESS, 64'h0000_0000_FFFF_FFFF, 64'd0, 1'b0},
        '{PREDICTED, CMD_COMPRESS,   64'h5555_5555_5555_5555, 64'd0, 1'b0},
        '{PREDICTED, CMD_DECOMPRESS, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0, 1'b0},
        '{PREDICTED, CMD_COMPRESS,   64'd100,        64'd0,          1'b0}
    };

    amount_compress_decompress_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] scale_wrap(input logic [63:0] v, input logic [63:0] k,
                                               inout logic ov);
        logic [67:0] p;
        p = 68'(v) * 68'(k);
        ov = ov | (|p[67:64]);
        return p[63:0];
    endfunction

    function automatic logic [63:0] sum_wrap(input logic [63:0] v, input logic [63:0] k,
                                             inout logic ov);
        logic [64:0] s;
        s = 65'(v) + 65'(k);
        ov = ov | s[64];
        return s[63:0];
    endfunction

    function automatic t_out predict_amount(input t_in req);
        logic [63:0] n;
        logic [63:0] d;
        logic [3:0]  e;
        logic        ov;
        ov = 1'b0;
        e  = 4'd0;
        n  = req.value;
        if (n == 64'd0) begin
            return '{result: 64'd0, overflow: 1'b0};
        end
        if (req.command == CMD_COMPRESS) begin
            while (n % DEC_RADIX == 64'd0 && e < E_MAX) begin
                n = n / DEC_RADIX;
                e = e + 4'd1;
            end
            if (e < E_MAX) begin
                d = n % DEC_RADIX;
                n = n / DEC_RADIX;
                n = scale_wrap(n, DIGIT_RADIX, ov);
                n = sum_wrap(n, d - 64'd1, ov);
                n = scale_wrap(n, DEC_RADIX, ov);
                n = sum_wrap(n, 64'(e), ov);
            end else begin
                n = scale_wrap(n - 64'd1, DEC_RADIX, ov);
                n = sum_wrap(n, 64'(E_MAX), ov);
            end
            n = sum_wrap(n, 64'd1, ov);
        end else begin
            n = n - 64'd1;
            e = 4'(n % DEC_RADIX);
            n = n / DEC_RADIX;
            if (e < E_MAX) begin
                d = n % DIGIT_RADIX + 64'd1;
                n = (n / DIGIT_RADIX) * DEC_RADIX + d;
            end else begin
                n = n + 64'd1;
            end
            while (e != 4'd0) begin
                n = scale_wrap(n, DEC_RADIX, ov);
                e = e - 4'd1;
            end
        end
        return '{result: n, overflow: ov};
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input t_in req, input t_out want);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_amounts.push_back(want);
        @(negedge i_clk);
    endtask

    initial begin : result_sink
        int unsigned wait_cycles;
        forever begin
            @(negedge i_clk);
            wait_cycles = burst_mode ? 0 : $urandom_range(0, 14);
            if (hold_request != 0) begin
                wait_cycles  = hold_request;
                hold_request = 0;
            end
            if (wait_cycles != 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_amounts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: result %h overflow %b",
                             o_out_data.result, o_out_data.overflow);
                end
            end else begin
                want = pending_amounts.pop_front();
                if (o_out_data.result !== want.result
                        || o_out_data.overflow !== want.overflow) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: result exp %h got %h, overflow exp %b got %b",
                                 want.result, o_out_data.result,
                                 want.overflow, o_out_data.overflow);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL amount_compress_decompress_core");
        $finish;
    end

    initial begin : stimulus
        t_in  req;
        t_out want;
        int unsigned idx;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        for (idx = 0; idx < DIRECTED_N; idx++) begin
            req.command = directed_rows[idx].command;
            req.value   = directed_rows[idx].value;
            if (directed_rows[idx].known) begin
                want = '{result: directed_rows[idx].result,
                         overflow: directed_rows[idx].overflow};
            end else begin
                want = predict_amount(req);
            end
            send_request(req, want);
        end

        // A burst stretch with no idling, then a long output hold-off while
        // requests keep coming, so that the core backs up into its input.
        for (idx = 0; idx < RANDOM_REQUESTS; idx++) begin
            burst_mode = (idx >= 300 && idx < 420) || (idx >= 900 && idx < 940);
            if (idx == 900) begin
                hold_request = 400;
            end
            req.command = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0: req.value = {$urandom, $urandom};
                1: req.value = 64'($urandom_range(0, 1000));
                2: begin
                    req.value = 64'($urandom);
                    repeat ($urandom_range(0, 12)) req.value = req.value * DEC_RADIX;
                end
                3: req.value = ALL_ONES - 64'($urandom_range(0, 200));
                4: req.value = {24'd0, 8'($urandom), $urandom};
                default: begin
                    req.value = 64'd1;
                    repeat ($urandom_range(0, 19)) req.value = req.value * DEC_RADIX;
                end
            endcase
            send_request(req, predict_amount(req));
        end
        burst_mode = 1'b0;
        in_valid <= 1'b0;

        while (pending_amounts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_amounts.size() == 0) begin
            $display("PASS amount_compress_decompress_core");
        end else begin
            $display("FAIL amount_compress_decompress_core");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- amount_compress_decompress_core.f -----
design/acdc_pkg.sv
design/acdc_datapath.sv
design/acdc_useq.sv
design/amount_compress_decompress_core.sv
design/acdc_checker.sv
verif/tb.sv
